// ===== sv/msec_pkg.sv =====
// ----------------------------------------------------------------------------
// msec_pkg: shared types and codes for the MIPS subset execute core
// Opcodes, function codes, access and fault codes, and the execute result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package msec_pkg;

  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_BGTZ    = 6'h07;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_COP0    = 6'h10;
  localparam logic [5:0] OPC_LB      = 6'h20;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_SH      = 6'h29;
  localparam logic [5:0] OPC_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [4:0] CP0_MF = 5'd0;
  localparam logic [4:0] CP0_MT = 5'd4;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic [2:0] ACC_NONE  = 3'd0;
  localparam logic [2:0] ACC_RD_W  = 3'd1;
  localparam logic [2:0] ACC_RD_B  = 3'd2;
  localparam logic [2:0] ACC_WR_W  = 3'd3;
  localparam logic [2:0] ACC_WR_H  = 3'd4;
  localparam logic [2:0] ACC_WR_B  = 3'd5;

  localparam logic [1:0] LD_NONE = 2'd0;
  localparam logic [1:0] LD_WORD = 2'd1;
  localparam logic [1:0] LD_BYTE = 2'd2;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_UNK   = 2'd1;
  localparam logic [1:0] FLT_ALIGN = 2'd2;
  localparam logic [1:0] FLT_OVF   = 2'd3;

  typedef struct packed {
    logic [31:0] pc_next;
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [31:0] sdata;
    logic [1:0]  flt;
    logic        gpr_we;
    logic [4:0]  gpr_waddr;
    logic [31:0] gpr_wdata;
    logic        cp0_we;
    logic [1:0]  ld_kind;
    logic [4:0]  ld_target;
  } exec_res_t;

endpackage
`default_nettype wire

// ===== sv/msec_ram.sv =====
// ----------------------------------------------------------------------------
// msec_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module msec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/msec_exec.sv =====
// ----------------------------------------------------------------------------
// msec_exec: execute logic for one instruction
// Decodes the executed word and yields next pc, access and write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module msec_exec import msec_pkg::*; (
  input  wire [31:0] instr,
  input  wire [31:0] iaddr,
  input  wire [31:0] pc,
  input  wire [31:0] a,
  input  wire [31:0] b,
  input  wire [31:0] cp0_rdata,
  output exec_res_t  res
);

  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [15:0] imm;
  logic [31:0] simm, zimm, sum_ab, sum_ai, br_tgt, j_tgt, link;
  logic        ovf_ab, ovf_ai;

  always_comb begin
    opc    = instr[31:26];
    rs     = instr[25:21];
    rt     = instr[20:16];
    rd     = instr[15:11];
    sa     = instr[10:6];
    fn     = instr[5:0];
    imm    = instr[15:0];
    simm   = {{16{imm[15]}}, imm};
    zimm   = {16'h0000, imm};
    sum_ab = a + b;
    sum_ai = a + simm;
    ovf_ab = ~(a[31] ^ b[31]) & (a[31] ^ sum_ab[31]);
    ovf_ai = ~(a[31] ^ simm[31]) & (a[31] ^ sum_ai[31]);
    br_tgt = pc + {simm[29:0], 2'b00};
    j_tgt  = {pc[31:28], instr[25:0], 2'b00};
    link   = iaddr + 32'd8;

    res           = '0;
    res.pc_next   = pc + 32'd4;
    res.gpr_waddr = rd;

    case (opc)
      OPC_SPECIAL: begin
        case (fn)
          FN_SLL: begin
            res.gpr_we = 1'b1; res.gpr_wdata = b << sa;
          end
          FN_JR: begin
            res.pc_next = a;
            if (a[1:0] != 2'b00) res.flt = FLT_ALIGN;
          end
          FN_JALR: begin
            res.pc_next = a;
            res.gpr_we = 1'b1; res.gpr_wdata = link;
            if (a[1:0] != 2'b00) res.flt = FLT_ALIGN;
          end
          FN_ADD: begin
            if (ovf_ab) res.flt = FLT_OVF;
            else begin
              res.gpr_we = 1'b1; res.gpr_wdata = sum_ab;
            end
          end
          FN_ADDU: begin
            res.gpr_we = 1'b1; res.gpr_wdata = sum_ab;
          end
          FN_AND: begin
            res.gpr_we = 1'b1; res.gpr_wdata = a & b;
          end
          FN_OR: begin
            res.gpr_we = 1'b1; res.gpr_wdata = a | b;
          end
          FN_SLTU: begin
            res.gpr_we = 1'b1; res.gpr_wdata = {31'd0, a < b};
          end
          default: res.flt = FLT_UNK;
        endcase
      end
      OPC_J: res.pc_next = j_tgt;
      OPC_JAL: begin
        res.pc_next = j_tgt;
        res.gpr_we = 1'b1; res.gpr_waddr = REG_RA; res.gpr_wdata = link;
      end
      OPC_BEQ:  if (a == b) res.pc_next = br_tgt;
      OPC_BNE:  if (a != b) res.pc_next = br_tgt;
      OPC_BGTZ: if (!a[31] && a != 32'd0) res.pc_next = br_tgt;
      OPC_ADDI: begin
        res.gpr_waddr = rt;
        if (ovf_ai) res.flt = FLT_OVF;
        else begin
          res.gpr_we = 1'b1; res.gpr_wdata = sum_ai;
        end
      end
      OPC_ADDIU: begin
        res.gpr_waddr = rt; res.gpr_we = 1'b1; res.gpr_wdata = sum_ai;
      end
      OPC_ANDI: begin
        res.gpr_waddr = rt; res.gpr_we = 1'b1; res.gpr_wdata = a & zimm;
      end
      OPC_ORI: begin
        res.gpr_waddr = rt; res.gpr_we = 1'b1; res.gpr_wdata = a | zimm;
      end
      OPC_LUI: begin
        res.gpr_waddr = rt; res.gpr_we = 1'b1; res.gpr_wdata = {imm, 16'h0000};
      end
      OPC_COP0: begin
        res.gpr_waddr = rt;
        if (fn != 6'd0) res.flt = FLT_UNK;
        else if (rs == CP0_MF) begin
          res.gpr_we = 1'b1; res.gpr_wdata = cp0_rdata;
        end else if (rs == CP0_MT) res.cp0_we = 1'b1;
        else res.flt = FLT_UNK;
      end
      OPC_LB: begin
        res.addr = sum_ai; res.kind = ACC_RD_B;
        res.ld_kind = LD_BYTE; res.ld_target = rt;
      end
      OPC_LW: begin
        res.addr = sum_ai; res.kind = ACC_RD_W;
        res.ld_kind = LD_WORD; res.ld_target = rt;
        if (sum_ai[1:0] != 2'b00) res.flt = FLT_ALIGN;
      end
      OPC_SB: begin
        res.addr = sum_ai; res.kind = ACC_WR_B; res.sdata = {24'd0, b[7:0]};
      end
      OPC_SH: begin
        res.addr = sum_ai; res.kind = ACC_WR_H; res.sdata = {16'd0, b[15:0]};
        if (sum_ai[0]) res.flt = FLT_ALIGN;
      end
      OPC_SW: begin
        res.addr = sum_ai; res.kind = ACC_WR_W; res.sdata = b;
        if (sum_ai[1:0] != 2'b00) res.flt = FLT_ALIGN;
      end
      default: res.flt = FLT_UNK;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/mips_subset_execute_core.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_core: MIPS-I integer subset with one delay slot
// Each input beat brings a fetched word or load data; each yields one result.
// ----------------------------------------------------------------------------
// channel | dir | handshake                 | payload
// s_*     | in  | s_tvalid / s_tready       | tuser op, tdata word + load data
// m_*     | out | m_tvalid / m_tready       | tuser access kind, tdata result
// apb     | in  | psel, penable, pwrite     | reset_vector at byte address 0
//
// One beat per cycle while the output is not stalled: a beat is captured in
// the input register; as it leaves, the held word executes from the register
// file, the beat's word becomes the held word, and the result lands in the
// output register.
// The input register advances while the output register is empty or drained,
// so a stalled result holds the pipe without dropping beats.
// Reset (synchronous) clears pc to the reset vector, CP0, valid bits and state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mips_subset_execute_core import msec_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // fetched_word[31:0], load_data[63:32]
  input  wire         s_tuser,   // op
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [103:0] m_tdata,  // fetch_address[31:0], access_address[63:32],
                                 // store_data[95:64], fault[97:96], zero pad
  output logic [2:0]  m_tuser,   // access_kind
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // input register
  logic        s1_valid, s1_op;
  logic [31:0] s1_word, s1_ldata;

  // output register
  logic        out_valid;
  logic [31:0] out_pc, out_addr, out_sdata;
  logic [2:0]  out_kind;
  logic [1:0]  out_flt;

  // architectural state
  logic [31:0] reset_vector, pc, held_word, held_addr;
  logic [4:0]  ld_target;
  logic [1:0]  ld_kind, halted;
  logic [31:0] cp0 [32];
  logic [31:0] gpr_valid;

  // register file bypass of the write that landed with the last read
  logic        byp_v;
  logic [4:0]  byp_a;
  logic [31:0] byp_d;
  logic        a_vld, b_vld;

  logic        out_free, fire, exec_go, cfg_we;
  logic        we;
  logic [4:0]  wa, ra, rb;
  logic [31:0] wd, ram_a, ram_b, a, b, ld_val, next_word;
  exec_res_t   ex;

  assign pready   = 1'b1;
  assign out_free = !out_valid || m_tready;
  assign fire     = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign exec_go  = fire && !s1_op && (halted == FLT_NONE);
  assign cfg_we   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata   = (paddr[2] == 1'b0) ? reset_vector : 32'd0;

  // read ports follow the word that will be executed next
  assign next_word = exec_go ? s1_word : held_word;
  assign ra        = next_word[25:21];
  assign rb        = next_word[20:16];

  always_comb begin
    a = 32'd0;
    if (held_word[25:21] != 5'd0) begin
      if (byp_v && byp_a == held_word[25:21]) a = byp_d;
      else if (a_vld) a = ram_a;
    end
    b = 32'd0;
    if (held_word[20:16] != 5'd0) begin
      if (byp_v && byp_a == held_word[20:16]) b = byp_d;
      else if (b_vld) b = ram_b;
    end
  end

  msec_exec u_exec (
    .instr     (held_word),
    .iaddr     (held_addr),
    .pc        (pc),
    .a         (a),
    .b         (b),
    .cp0_rdata (cp0[held_word[15:11]]),
    .res       (ex)
  );

  // write-back select: load return or executed instruction; drop writes to r0
  always_comb begin
    ld_val = (ld_kind == LD_BYTE) ? {{24{s1_ldata[7]}}, s1_ldata[7:0]} : s1_ldata;
    we = 1'b0;
    wa = ld_target;
    wd = ld_val;
    if (fire && s1_op) begin
      we = (ld_kind != LD_NONE) && (ld_target != 5'd0);
    end else if (exec_go) begin
      we = ex.gpr_we && (ex.gpr_waddr != 5'd0);
      wa = ex.gpr_waddr;
      wd = ex.gpr_wdata;
    end
  end

  msec_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_a (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(ram_a)
  );
  msec_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_b (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(rb), .rdata(ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_v     <= 1'b0;
      gpr_valid <= '0;
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
    end else begin
      byp_v <= we;
      a_vld <= gpr_valid[ra];
      b_vld <= gpr_valid[rb];
      if (we) gpr_valid[wa] <= 1'b1;
    end
    byp_a <= wa;
    byp_d <= wd;
  end

  // input register: hold while the output side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      s1_op    <= s_tuser;
      s1_word  <= s_tdata[31:0];
      s1_ldata <= s_tdata[63:32];
    end
  end

  // architectural state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_vector <= 32'hBFC00000;
      pc           <= 32'hBFC00000;
      held_word    <= 32'd0;
      held_addr    <= 32'd0;
      ld_target    <= 5'd0;
      ld_kind      <= LD_NONE;
      halted       <= FLT_NONE;
      out_valid    <= 1'b0;
      for (int i = 0; i < 32; i++) cp0[i] <= 32'd0;
    end else begin
      if (cfg_we) begin
        reset_vector <= pwdata;
        pc           <= pwdata;
      end
      if (out_free) out_valid <= fire;
      if (fire) begin
        out_pc    <= pc;
        out_kind  <= ACC_NONE;
        out_addr  <= 32'd0;
        out_sdata <= 32'd0;
        out_flt   <= halted;
        if (s1_op) begin
          // complete the pending load, if any
          ld_kind   <= LD_NONE;
          ld_target <= 5'd0;
        end else if (halted == FLT_NONE) begin
          held_word <= s1_word;
          held_addr <= pc;
          pc        <= ex.pc_next;
          ld_kind   <= ex.ld_kind;
          ld_target <= ex.ld_target;
          if (ex.cp0_we) cp0[held_word[15:11]] <= b;
          if (ex.flt != FLT_NONE) halted <= ex.flt;
          out_pc    <= ex.pc_next;
          out_kind  <= ex.kind;
          out_addr  <= ex.addr;
          out_sdata <= ex.sdata;
          out_flt   <= ex.flt;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_flt, out_sdata, out_addr, out_pc};

endmodule
`default_nettype wire

// ===== sv/msec_checker.sv =====
// ----------------------------------------------------------------------------
// msec_checker: port-level checks for the execute core
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module msec_checker import msec_pkg::*; (
  input wire         clk,
  input wire         rst,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [103:0] m_tdata,
  input wire [2:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_no_acc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ACC_NONE |-> m_tdata[63:32] == 32'd0 && m_tdata[95:64] == 32'd0)
    else $error("address or store data without an access");

  a_rd_sdata: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ACC_RD_W || m_tuser == ACC_RD_B) |-> m_tdata[95:64] == 32'd0)
    else $error("store data on a read access");

  a_unk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[97:96] == FLT_UNK |-> m_tuser == ACC_NONE)
    else $error("access on unknown instruction");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind mips_subset_execute_core msec_checker u_msec_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
